@@ sv/spfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spfr_pkg;

  localparam logic [7:0] SYNC_A = 8'h73;
  localparam logic [7:0] SYNC_B = 8'h79;
  localparam logic [7:0] SYNC_C = 8'h6E;
  localparam logic [7:0] SYNC_D = 8'h63;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS = 2'd1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic  valid;
    beat_t beat;
  } res_t;

endpackage

`default_nettype wire

@@ sv/spfr_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spfr_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         acc,
  input  wire logic [7:0]   rx_byte,
  input  wire logic [31:0]  own_id,
  input  wire logic         continuous,
  output spfr_pkg::res_t    res
);

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_S1   = 4'd1,
    PH_S2   = 4'd2,
    PH_S3   = 4'd3,
    PH_ID0  = 4'd4,
    PH_ID1  = 4'd5,
    PH_ID2  = 4'd6,
    PH_ID3  = 4'd7,
    PH_LEN0 = 4'd8,
    PH_LEN1 = 4'd9,
    PH_DATA = 4'd10
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] sender_id_r, sender_id_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic        finished_r, finished_nxt;
  logic [15:0] left_dec;
  logic        is_last;
  phase_t      resync_phase;

  assign resync_phase = (rx_byte == spfr_pkg::SYNC_A) ? PH_S1 : PH_HUNT;
  assign left_dec     = (bytes_left_r != 16'd0) ? (bytes_left_r - 16'd1) : bytes_left_r;
  assign is_last      = (left_dec == 16'd0);

  always_comb begin
    phase_nxt             = phase_r;
    sender_id_nxt         = sender_id_r;
    bytes_left_nxt        = bytes_left_r;
    finished_nxt          = finished_r;
    res.valid             = 1'b0;
    res.beat.payload_byte = rx_byte;
    res.beat.last_byte    = is_last;
    if (acc && !finished_r) begin
      case (phase_r)
        PH_HUNT: phase_nxt = resync_phase;
        PH_S1:   phase_nxt = (rx_byte == spfr_pkg::SYNC_B) ? PH_S2 : resync_phase;
        PH_S2:   phase_nxt = (rx_byte == spfr_pkg::SYNC_C) ? PH_S3 : resync_phase;
        PH_S3: begin
          if (rx_byte == spfr_pkg::SYNC_D) begin
            sender_id_nxt  = 32'd0;
            bytes_left_nxt = 16'd0;
            phase_nxt      = PH_ID0;
          end else begin
            phase_nxt = resync_phase;
          end
        end
        PH_ID0: begin
          sender_id_nxt = {rx_byte, 24'd0};
          phase_nxt     = PH_ID1;
        end
        PH_ID1: begin
          sender_id_nxt = {sender_id_r[31:24], rx_byte, sender_id_r[15:0]};
          phase_nxt     = PH_ID2;
        end
        PH_ID2: begin
          sender_id_nxt = {sender_id_r[31:16], rx_byte, sender_id_r[7:0]};
          phase_nxt     = PH_ID3;
        end
        PH_ID3: begin
          sender_id_nxt = {sender_id_r[31:8], rx_byte};
          phase_nxt     = PH_LEN0;
        end
        PH_LEN0: begin
          bytes_left_nxt = {rx_byte, 8'd0};
          phase_nxt      = PH_LEN1;
        end
        PH_LEN1: begin
          bytes_left_nxt = {bytes_left_r[15:8], rx_byte};
          phase_nxt      = ({bytes_left_r[15:8], rx_byte} != 16'd0) ? PH_DATA : PH_HUNT;
        end
        PH_DATA: begin
          bytes_left_nxt = left_dec;
          if (is_last) begin
            phase_nxt = PH_HUNT;
            if (!continuous) begin
              finished_nxt = 1'b1;
            end
          end
          res.valid = (sender_id_r == own_id);
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      sender_id_r  <= 32'd0;
      bytes_left_r <= 16'd0;
      finished_r   <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      sender_id_r  <= sender_id_nxt;
      bytes_left_r <= bytes_left_nxt;
      finished_r   <= finished_nxt;
    end
  end

  a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (bytes_left_r != 16'd0))
    else $error("payload phase with no bytes left");

  a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag cleared without reset");

  a_finished_silent: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !res.valid)
    else $error("result produced after one-shot completion");

endmodule

`default_nettype wire

@@ sv/spfr_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spfr_out_buf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire spfr_pkg::res_t push,
  output logic                can_take,
  output logic                out_valid,
  input  wire logic           out_ready,
  output spfr_pkg::beat_t     out_beat
);

  logic            out_valid_r, out_valid_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  spfr_pkg::beat_t out_r, out_nxt;
  spfr_pkg::beat_t skid_r, skid_nxt;
  logic            head_free;

  assign head_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (head_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = push.valid;
        skid_nxt       = push.beat;
      end else begin
        out_valid_nxt = push.valid;
        out_nxt       = push.beat;
      end
    end else if (push.valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push.beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign can_take  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("second entry held while head is empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && skid_valid_r) |-> head_free)
    else $error("beat pushed into a full buffer");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && !out_valid_r) |=> out_valid_r)
    else $error("beat pushed into an empty buffer was lost");

endmodule

`default_nettype wire

@@ sv/sync_pid_len_frame_receiver_core.sv @@
// Frame receiver: takes one received byte per input beat and deframes
// messages of the form "sync" marker, 4-byte big-endian sender id, 2-byte
// big-endian length, then the payload. Payload bytes of frames whose id
// matches own_id leave on the output channel, the final one with last_byte.
// Frames with other ids are consumed with no output.
// Input channel: in_valid/in_ready with in_rx_byte. Output channel:
// out_valid/out_ready with out_payload_byte and out_last_byte.
// Configuration: write cfg_wdata to register cfg_index while cfg_wr_en is
// high; index 0 is own_id, index 1 is continuous. Write only while idle.
// Throughput is one byte per cycle while in_ready is high. A payload beat
// is registered in the output buffer before it is presented on the output.
// The output holds up to two beats, so after the receiver stalls the input
// keeps flowing until a second payload beat is waiting; in_ready drops once
// both entries are full and rises in the cycle after the receiver takes a beat.
// Reset clears the parser, the output buffer and both registers. With
// continuous clear, the block ignores all bytes after the first frame that
// carries a payload, until the next reset.
`timescale 1ns / 1ps
`default_nettype none

module sync_pid_len_frame_receiver_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_rx_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             out_payload_byte,
  output logic                                   out_last_byte,
  input  wire logic                              cfg_wr_en,
  input  wire logic [spfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [spfr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [31:0]     own_id_r;
  logic            continuous_r;
  logic            in_acc;
  spfr_pkg::res_t  res;
  spfr_pkg::beat_t out_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r     <= 32'd0;
      continuous_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        spfr_pkg::CFG_OWN_ID:     own_id_r     <= cfg_wdata[31:0];
        spfr_pkg::CFG_CONTINUOUS: continuous_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_acc = in_valid && in_ready;

  spfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .rx_byte    (in_rx_byte),
    .own_id     (own_id_r),
    .continuous (continuous_r),
    .res        (res)
  );

  spfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  assign out_payload_byte = out_beat.payload_byte;
  assign out_last_byte    = out_beat.last_byte;

endmodule

`default_nettype wire
